>>> src/elevator_group_dispatcher_top_macros.svh
// assertion macros shared by the elevator group dispatcher
`ifndef ELEVATOR_GROUP_DISPATCHER_TOP_MACROS_SVH
`define ELEVATOR_GROUP_DISPATCHER_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define EGD_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define EGD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/egd_pkg.sv
// shared types, codes and sizes of the elevator group dispatcher
package egd_pkg;

    localparam int NUM_CARS   = 4;
    localparam int NUM_FLOORS = 16;
    localparam int CAR_W      = 2;
    localparam int FLOOR_W    = 4;

    localparam logic FUNC_REQUEST = 1'b0;
    localparam logic FUNC_TICK    = 1'b1;

    localparam logic KIND_ANSWER = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    localparam logic [1:0] ST_ASSIGNED = 2'd0;
    localparam logic [1:0] ST_NO_IDLE  = 2'd1;
    localparam logic [1:0] ST_INVALID  = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_ANSWER,
        S_REPORT
    } state_t;

    typedef struct packed {
        logic req_load;
        logic scan_step;
        logic answer;
        logic tick_update;
        logic report;
    } cmd_t;

    typedef struct packed {
        logic cnt_last;
        logic out_free;
    } sts_t;

    typedef struct packed {
        logic [FLOOR_W-1:0] floor_now;
        logic [FLOOR_W-1:0] target_floor;
        logic [FLOOR_W-1:0] pending_dest;
        logic               busy;
        logic               leg_pending;
    } car_t;

    typedef struct packed {
        logic               kind;
        logic [1:0]         status;
        logic [CAR_W-1:0]   car_index;
        logic [FLOOR_W-1:0] car_floor;
        logic               car_busy;
        logic               car_arrived;
        logic               any_moving;
        logic               last;
    } res_t;

endpackage

>>> src/egd_ctrl.sv
// controller state machine: sequences request scans and tick reports
module egd_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    input  logic          in_func,
    input  egd_pkg::sts_t sts,
    output logic          in_ready,
    output egd_pkg::cmd_t cmd
);

    egd_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= egd_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            egd_pkg::S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    if (in_func == egd_pkg::FUNC_TICK) begin
                        cmd.tick_update = 1'b1;
                        state_next      = egd_pkg::S_REPORT;
                    end else begin
                        cmd.req_load = 1'b1;
                        state_next   = egd_pkg::S_SCAN;
                    end
                end
            end
            egd_pkg::S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.cnt_last) begin
                    state_next = egd_pkg::S_ANSWER;
                end
            end
            egd_pkg::S_ANSWER: begin
                if (sts.out_free) begin
                    cmd.answer = 1'b1;
                    state_next = egd_pkg::S_IDLE;
                end
            end
            egd_pkg::S_REPORT: begin
                if (sts.out_free) begin
                    cmd.report = 1'b1;
                    if (sts.cnt_last) begin
                        state_next = egd_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                state_next = egd_pkg::S_IDLE;
            end
        endcase
    end

endmodule

>>> src/egd_datapath.sv
// car state, nearest-idle scan, tick motion and result register
module egd_datapath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  egd_pkg::cmd_t               cmd,
    input  logic [egd_pkg::FLOOR_W-1:0] pickup_floor,
    input  logic [egd_pkg::FLOOR_W-1:0] dest_floor,
    input  logic                        out_ready,
    output egd_pkg::sts_t               sts,
    output logic                        out_valid,
    output egd_pkg::res_t               res
);

    egd_pkg::car_t cars_reg [egd_pkg::NUM_CARS];
    egd_pkg::car_t cars_next [egd_pkg::NUM_CARS];
    logic          arrived_reg [egd_pkg::NUM_CARS];
    logic          arrived_next [egd_pkg::NUM_CARS];

    logic [egd_pkg::CAR_W-1:0]   cnt_reg;
    logic [egd_pkg::FLOOR_W-1:0] pick_reg;
    logic [egd_pkg::FLOOR_W-1:0] dest_reg;
    logic                        bad_reg;
    logic                        best_valid_reg;
    logic [egd_pkg::CAR_W-1:0]   best_idx_reg;
    logic [egd_pkg::FLOOR_W-1:0] best_dist_reg;
    logic [egd_pkg::FLOOR_W-1:0] best_floor_reg;
    logic                        out_valid_reg;
    egd_pkg::res_t               res_reg;
    egd_pkg::res_t               res_next;

    egd_pkg::car_t               cur_car;
    logic [egd_pkg::FLOOR_W-1:0] cur_dist;
    logic                        cur_better;
    logic                        any_busy;
    logic                        out_free;
    logic                        cnt_last;

    // one tick of motion for one car
    function automatic egd_pkg::car_t car_tick(input egd_pkg::car_t c_in);
        egd_pkg::car_t c;
        c = c_in;
        if (c.busy) begin
            if (c.leg_pending && c.floor_now == c.target_floor) begin
                c.target_floor = c.pending_dest;
                c.leg_pending  = 1'b0;
            end
            if (c.floor_now < c.target_floor) begin
                c.floor_now = c.floor_now + 1'b1;
            end else if (c.floor_now > c.target_floor) begin
                c.floor_now = c.floor_now - 1'b1;
            end
            if (c.leg_pending && c.floor_now == c.target_floor) begin
                c.target_floor = c.pending_dest;
                c.leg_pending  = 1'b0;
            end
            if (c.floor_now == c.target_floor && !c.leg_pending) begin
                c.busy = 1'b0;
            end
        end
        return c;
    endfunction

    assign cur_car  = cars_reg[cnt_reg];
    assign cur_dist = (cur_car.floor_now > pick_reg) ? cur_car.floor_now - pick_reg
                                                     : pick_reg - cur_car.floor_now;
    assign cur_better = !cur_car.busy && (!best_valid_reg || cur_dist < best_dist_reg);
    assign cnt_last   = (cnt_reg == egd_pkg::CAR_W'(egd_pkg::NUM_CARS - 1));
    assign out_free   = !out_valid_reg || out_ready;

    always_comb begin
        any_busy = 1'b0;
        for (int i = 0; i < egd_pkg::NUM_CARS; i++) begin
            any_busy = any_busy | cars_reg[i].busy;
        end
    end

    // next car state
    always_comb begin
        for (int i = 0; i < egd_pkg::NUM_CARS; i++) begin
            cars_next[i]    = cars_reg[i];
            arrived_next[i] = arrived_reg[i];
            if (cmd.tick_update) begin
                cars_next[i]    = car_tick(cars_reg[i]);
                arrived_next[i] = cars_reg[i].busy && !cars_next[i].busy;
            end
        end
        if (cmd.answer && !bad_reg && best_valid_reg) begin
            cars_next[best_idx_reg].target_floor = pick_reg;
            cars_next[best_idx_reg].pending_dest = dest_reg;
            cars_next[best_idx_reg].leg_pending  = 1'b1;
            cars_next[best_idx_reg].busy         = 1'b1;
        end
    end

    // next result
    always_comb begin
        res_next            = '0;
        res_next.any_moving = any_busy;
        if (cmd.report) begin
            res_next.kind        = egd_pkg::KIND_REPORT;
            res_next.status      = egd_pkg::ST_ASSIGNED;
            res_next.car_index   = cnt_reg;
            res_next.car_floor   = cur_car.floor_now;
            res_next.car_busy    = cur_car.busy;
            res_next.car_arrived = arrived_reg[cnt_reg];
            res_next.last        = cnt_last;
        end else begin
            res_next.kind = egd_pkg::KIND_ANSWER;
            res_next.last = 1'b1;
            if (bad_reg) begin
                res_next.status = egd_pkg::ST_INVALID;
            end else if (!best_valid_reg) begin
                res_next.status = egd_pkg::ST_NO_IDLE;
            end else begin
                res_next.status     = egd_pkg::ST_ASSIGNED;
                res_next.car_index  = best_idx_reg;
                res_next.car_floor  = best_floor_reg;
                res_next.car_busy   = 1'b1;
                res_next.any_moving = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < egd_pkg::NUM_CARS; i++) begin
                cars_reg[i]    <= '0;
                arrived_reg[i] <= 1'b0;
            end
            cnt_reg        <= '0;
            best_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            for (int i = 0; i < egd_pkg::NUM_CARS; i++) begin
                cars_reg[i]    <= cars_next[i];
                arrived_reg[i] <= arrived_next[i];
            end
            if (cmd.req_load || cmd.tick_update) begin
                cnt_reg <= '0;
            end else if (cmd.scan_step || cmd.report) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.req_load) begin
                best_valid_reg <= 1'b0;
            end else if (cmd.scan_step && cur_better) begin
                best_valid_reg <= 1'b1;
            end
            if (cmd.answer || cmd.report) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.req_load) begin
            pick_reg <= pickup_floor;
            dest_reg <= dest_floor;
            bad_reg  <= ({1'b0, pickup_floor} >= (egd_pkg::FLOOR_W + 1)'(egd_pkg::NUM_FLOORS))
                     || ({1'b0, dest_floor} >= (egd_pkg::FLOOR_W + 1)'(egd_pkg::NUM_FLOORS));
        end
        if (cmd.scan_step && cur_better) begin
            best_idx_reg   <= cnt_reg;
            best_dist_reg  <= cur_dist;
            best_floor_reg <= cur_car.floor_now;
        end
        if (cmd.answer || cmd.report) begin
            res_reg <= res_next;
        end
    end

    assign sts.cnt_last = cnt_last;
    assign sts.out_free = out_free;
    assign out_valid    = out_valid_reg;
    assign res          = res_reg;

endmodule

>>> src/elevator_group_dispatcher_top.sv
// Elevator group dispatcher, top level. Takes request items (tuser 0: pickup and
// destination floor) and tick items (tuser 1). A request is checked against the floor
// count, then a scan visits one car per cycle to find the idle car nearest the pickup
// floor (ties to the lowest index); one answer follows once the output register is free,
// and the next item is taken only after that answer is loaded. A tick moves every busy
// car by at most one floor (pickup first, then destination) and then sends one report
// per car, one per cycle while the output register is free, the last marked by tlast;
// the next item is taken only after the last report is loaded. The sequencer walks the
// car registers one car at a time; a result held in the output register does not hold
// back acceptance of the next request, but a new result waits until the output register
// is free.
`include "elevator_group_dispatcher_top_macros.svh"

module elevator_group_dispatcher_top (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [3:0] pickup_floor, [7:4] dest_floor
    input  logic        s_tuser,   // [0] func
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [1:0] status, [3:2] car_index, [7:4] car_floor,
                                   // [8] car_busy, [9] car_arrived, [10] any_moving
    output logic        m_tuser,   // [0] kind
    output logic        m_tlast    // last result of this request or tick
);

    egd_pkg::cmd_t cmd;
    egd_pkg::sts_t sts;
    egd_pkg::res_t res;

    // sequencer
    egd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_func  (s_tuser),
        .sts      (sts),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    // car registers, scan and output register
    egd_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .pickup_floor (s_tdata[3:0]),
        .dest_floor   (s_tdata[7:4]),
        .out_ready    (m_tready),
        .sts          (sts),
        .out_valid    (m_tvalid),
        .res          (res)
    );

    // pack result fields, lowest bit first
    assign m_tdata = {5'b0, res.any_moving, res.car_arrived, res.car_busy,
                      res.car_floor, res.car_index, res.status};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

    // a request answer is always the only and thus last result of its request
    `EGD_ASSERT_NOW(a_answer_last, aclk, aresetn,
        m_tvalid && m_tuser == egd_pkg::KIND_ANSWER, m_tlast,
        "request answer without tlast")

    // an assigned car is busy, so the group reports motion
    `EGD_ASSERT_NOW(a_assigned_moving, aclk, aresetn,
        m_tvalid && m_tuser == egd_pkg::KIND_ANSWER && m_tdata[1:0] == egd_pkg::ST_ASSIGNED,
        m_tdata[8] && m_tdata[10],
        "assigned answer without busy car")

    // the sequencer is busy in the cycle after taking a request
    `EGD_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn,
        s_tvalid && s_tready, !s_tready,
        "request taken while previous one still in work")

endmodule

>>> tb/elevator_group_dispatcher_top_test.sv
// testbench for the elevator group dispatcher: self-checking stream test
`timescale 1ns / 1ps

module elevator_group_dispatcher_top_test;

    // no-acceptance cycles before the run is declared hung
    localparam int STALL_LIMIT  = 1000;
    // cycles allowed after the last result for stray output
    localparam int DRAIN_CYCLES = 24;
    localparam int MAX_SHOWN    = 10;

    typedef enum int {
        RX_READY,
        RX_PATTERN,
        RX_RANDOM
    } rx_mode_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [3:0] pickup_floor, [7:4] dest_floor
    logic        s_tuser;   // [0] func
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [1:0] status, [3:2] car_index, [7:4] car_floor,
                            // [8] car_busy, [9] car_arrived, [10] any_moving
    logic        m_tuser;   // [0] kind
    logic        m_tlast;

    // predicted car group and the results it still owes
    egd_pkg::car_t car_state [egd_pkg::NUM_CARS];
    egd_pkg::res_t pending_results [$];

    // sender burst shaping
    int          burst_left;
    bit          no_gaps;

    // receiver stall shaping
    rx_mode_t    rx_mode;
    logic [15:0] stall_pattern;
    int          pattern_age;

    // bookkeeping
    int          mismatches;
    int          results_checked;
    int          stalled_cycles;
    int          n_requests;
    int          n_ticks;
    int          n_assigned;
    int          n_no_idle;
    int          n_arrivals;

    elevator_group_dispatcher_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // 10 ns clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // group predictor
    // ------------------------------------------------------------------

    function automatic logic group_moving();
        for (int c = 0; c < egd_pkg::NUM_CARS; c++) begin
            if (car_state[c].busy) return 1'b1;
        end
        return 1'b0;
    endfunction

    // once a car stands at its pickup floor it heads for the destination
    function automatic void advance_leg(input int c);
        if (car_state[c].leg_pending &&
            car_state[c].floor_now == car_state[c].target_floor) begin
            car_state[c].target_floor = car_state[c].pending_dest;
            car_state[c].leg_pending  = 1'b0;
        end
    endfunction

    // works out the results one request causes and queues them
    function automatic void predict_dispatch(input logic func,
                                             input logic [egd_pkg::FLOOR_W-1:0] pick,
                                             input logic [egd_pkg::FLOOR_W-1:0] dest);
        egd_pkg::res_t r;
        int   best;
        int   best_dist;
        int   car_dist;
        logic arrived [egd_pkg::NUM_CARS];
        logic moving;

        if (func == egd_pkg::FUNC_REQUEST) begin
            n_requests++;
            r      = '0;
            r.kind = egd_pkg::KIND_ANSWER;
            r.last = 1'b1;
            if (int'(pick) >= egd_pkg::NUM_FLOORS || int'(dest) >= egd_pkg::NUM_FLOORS) begin
                // floor out of range: nothing changes
                r.status     = egd_pkg::ST_INVALID;
                r.any_moving = group_moving();
            end else begin
                best      = -1;
                best_dist = 0;
                for (int c = 0; c < egd_pkg::NUM_CARS; c++) begin
                    if (!car_state[c].busy) begin
                        car_dist = int'(car_state[c].floor_now) - int'(pick);
                        if (car_dist < 0) car_dist = -car_dist;
                        // strict compare keeps the lowest index on a tie
                        if (best < 0 || car_dist < best_dist) begin
                            best      = c;
                            best_dist = car_dist;
                        end
                    end
                end
                if (best < 0) begin
                    n_no_idle++;
                    r.status     = egd_pkg::ST_NO_IDLE;
                    r.any_moving = group_moving();
                end else begin
                    n_assigned++;
                    car_state[best].target_floor = pick;
                    car_state[best].pending_dest = dest;
                    car_state[best].leg_pending  = 1'b1;
                    car_state[best].busy         = 1'b1;
                    r.status     = egd_pkg::ST_ASSIGNED;
                    r.car_index  = (egd_pkg::CAR_W)'(best);
                    r.car_floor  = car_state[best].floor_now;
                    r.car_busy   = 1'b1;
                    r.any_moving = 1'b1;
                end
            end
            pending_results.push_back(r);
        end else begin
            n_ticks++;
            for (int c = 0; c < egd_pkg::NUM_CARS; c++) begin
                arrived[c] = 1'b0;
                if (car_state[c].busy) begin
                    advance_leg(c);
                    if (car_state[c].floor_now < car_state[c].target_floor)
                        car_state[c].floor_now = car_state[c].floor_now + 1'b1;
                    else if (car_state[c].floor_now > car_state[c].target_floor)
                        car_state[c].floor_now = car_state[c].floor_now - 1'b1;
                    advance_leg(c);
                    if (car_state[c].floor_now == car_state[c].target_floor &&
                        !car_state[c].leg_pending) begin
                        car_state[c].busy = 1'b0;
                        arrived[c]        = 1'b1;
                        n_arrivals++;
                    end
                end
            end
            moving = group_moving();
            for (int c = 0; c < egd_pkg::NUM_CARS; c++) begin
                r             = '0;
                r.kind        = egd_pkg::KIND_REPORT;
                r.car_index   = (egd_pkg::CAR_W)'(c);
                r.car_floor   = car_state[c].floor_now;
                r.car_busy    = car_state[c].busy;
                r.car_arrived = arrived[c];
                r.any_moving  = moving;
                r.last        = (c == egd_pkg::NUM_CARS - 1);
                pending_results.push_back(r);
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // request driver
    // ------------------------------------------------------------------

    // offers one request in bursts with random gaps; returns on the edge
    // at which it was taken, leaving tvalid high for a back-to-back request
    task automatic send_item(input logic func,
                             input logic [egd_pkg::FLOOR_W-1:0] pick,
                             input logic [egd_pkg::FLOOR_W-1:0] dest);
        int gap;
        if (burst_left == 0) begin
            gap        = no_gaps ? 0 : $urandom_range(0, 7);
            burst_left = $urandom_range(1, 10);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {dest, pick};
        // inputs only move on rising edges, so the falling edge shows what
        // the next rising edge will see
        @(negedge aclk);
        while (!s_tready) @(negedge aclk);
        predict_dispatch(func, pick, dest);
        @(posedge aclk);
    endtask

    task automatic send_random(input int count, input int request_pct);
        logic [egd_pkg::FLOOR_W-1:0] pick;
        logic [egd_pkg::FLOOR_W-1:0] dest;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, egd_pkg::NUM_FLOORS - 1);
            dest = $urandom_range(0, egd_pkg::NUM_FLOORS - 1);
            // change the traffic shape every few dozen requests
            if (i % 40 == 0) begin
                no_gaps = ($urandom_range(0, 3) == 0);
                rx_mode = rx_mode_t'($urandom_range(0, 2));
            end
            if ($urandom_range(0, 99) < request_pct)
                send_item(egd_pkg::FUNC_REQUEST, pick, dest);
            else
                send_item(egd_pkg::FUNC_TICK, pick, dest);
        end
    endtask

    // ------------------------------------------------------------------
    // result receiver and checker
    // ------------------------------------------------------------------

    // tready follows its own pattern, independent of the sender
    always @(posedge aclk) begin
        case (rx_mode)
            RX_READY: begin
                m_tready <= 1'b1;
            end
            RX_PATTERN: begin
                m_tready    <= stall_pattern[0];
                pattern_age <= pattern_age + 1;
                if (pattern_age % 64 == 63)
                    stall_pattern <= 16'($urandom()) | 16'h0001;
                else
                    stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
            end
            default: begin
                m_tready <= ($urandom_range(0, 3) != 0);
            end
        endcase
    end

    always @(negedge aclk) begin : result_check
        egd_pkg::res_t got;
        egd_pkg::res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got             = '0;
            got.kind        = m_tuser;
            got.status      = m_tdata[1:0];
            got.car_index   = m_tdata[3:2];
            got.car_floor   = m_tdata[7:4];
            got.car_busy    = m_tdata[8];
            got.car_arrived = m_tdata[9];
            got.any_moving  = m_tdata[10];
            got.last        = m_tlast;
            results_checked++;
            if (pending_results.size() == 0) begin
                if (mismatches < MAX_SHOWN)
                    $display("[%0t] unexpected result kind=%0d status=%0d car=%0d",
                             $realtime, got.kind, got.status, got.car_index);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (got.kind !== want.kind || got.status !== want.status ||
                    got.car_index !== want.car_index ||
                    got.car_floor !== want.car_floor ||
                    got.car_busy !== want.car_busy ||
                    got.car_arrived !== want.car_arrived ||
                    got.any_moving !== want.any_moving || got.last !== want.last) begin
                    if (mismatches < MAX_SHOWN) begin
                        $display("[%0t] result mismatch", $realtime);
                        $display("  expected kind=%0d status=%0d car=%0d floor=%0d",
                                 want.kind, want.status, want.car_index, want.car_floor);
                        $display("           busy=%0d arrived=%0d moving=%0d last=%0d",
                                 want.car_busy, want.car_arrived, want.any_moving,
                                 want.last);
                        $display("  actual   kind=%0d status=%0d car=%0d floor=%0d",
                                 got.kind, got.status, got.car_index, got.car_floor);
                        $display("           busy=%0d arrived=%0d moving=%0d last=%0d",
                                 got.car_busy, got.car_arrived, got.any_moving,
                                 got.last);
                    end
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // hang detection: ends the run when nothing moves on either channel
    // ------------------------------------------------------------------

    initial begin : watchdog
        stalled_cycles = 0;
        while (stalled_cycles < STALL_LIMIT) begin
            @(negedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stalled_cycles = 0;
            else
                stalled_cycles++;
        end
        $display("[%0t] no handshake for %0d cycles", $realtime, STALL_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // a tick with the whole group parked: nobody moves or arrives
    task automatic test_idle_tick();
        no_gaps = 1'b1;
        rx_mode = RX_READY;
        send_item(egd_pkg::FUNC_TICK, 4'd0, 4'd0);
    endtask

    // all cars start on floor 0, so ties pick the lowest free index; the
    // fifth request finds every car busy
    task automatic test_nearest_and_no_idle();
        no_gaps = 1'b0;
        send_item(egd_pkg::FUNC_REQUEST, 4'd15, 4'd15);
        send_item(egd_pkg::FUNC_REQUEST, 4'd0, 4'd0);
        send_item(egd_pkg::FUNC_REQUEST, 4'd0, 4'd3);
        send_item(egd_pkg::FUNC_REQUEST, 4'd1, 4'd0);
        send_item(egd_pkg::FUNC_REQUEST, 4'd7, 4'd7);
    endtask

    // zero-length trips finish on the next tick, a car waiting at its pickup
    // floor turns toward the destination and moves on the same tick
    task automatic test_pickup_and_short_trips();
        rx_mode = RX_PATTERN;
        send_item(egd_pkg::FUNC_TICK, 4'd0, 4'd0);
        send_item(egd_pkg::FUNC_TICK, 4'd15, 4'd15);
        send_item(egd_pkg::FUNC_REQUEST, 4'd0, 4'd15);
        send_item(egd_pkg::FUNC_REQUEST, 4'd15, 4'd0);
        repeat (4) send_item(egd_pkg::FUNC_TICK, 4'd0, 4'd0);
        send_item(egd_pkg::FUNC_REQUEST, 4'd8, 4'd8);
        send_item(egd_pkg::FUNC_REQUEST, 4'd15, 4'd0);
        send_item(egd_pkg::FUNC_TICK, 4'd0, 4'd0);
    endtask

    // balanced traffic: trips get long enough to cross the whole building
    task automatic test_mixed_traffic();
        send_random(300, 40);
    endtask

    // request-heavy traffic keeps the group full and exercises refusals
    task automatic test_saturated_group();
        send_random(120, 75);
    endtask

    initial begin : main
        for (int c = 0; c < egd_pkg::NUM_CARS; c++) car_state[c] = '0;
        burst_left      = 0;
        no_gaps         = 1'b1;
        rx_mode         = RX_READY;
        stall_pattern   = 16'hb3a5;
        pattern_age     = 0;
        mismatches      = 0;
        results_checked = 0;
        n_requests      = 0;
        n_ticks         = 0;
        n_assigned      = 0;
        n_no_idle       = 0;
        n_arrivals      = 0;

        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= egd_pkg::FUNC_REQUEST;
        m_tready <= 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_idle_tick();
        test_nearest_and_no_idle();
        test_pickup_and_short_trips();
        test_mixed_traffic();
        test_saturated_group();

        // drain: every owed result, then a quiet tail for strays
        s_tvalid <= 1'b0;
        rx_mode  = RX_RANDOM;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (pending_results.size() != 0) begin
            $display("%0d results never arrived", pending_results.size());
            mismatches++;
        end
        if (mismatches > 0)
            $display("%0d mismatches in total", mismatches);

        $display("covered %0d passenger calls (%0d dispatched, %0d refused for a full group)",
                 n_requests, n_assigned, n_no_idle);
        $display("and %0d ticks with %0d trips completed; %0d results checked",
                 n_ticks, n_arrivals, results_checked);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
